// ----- hw/rtl/bcfs_pkg.sv -----
// ----------------------------------------------------------------------------
// bcfs_pkg
// Shared types and codes for the BCD clock field setter: event opcodes,
// edit modes, display pages, RTC register numbers and the state records.
// ----------------------------------------------------------------------------
package bcfs_pkg;

  // event opcodes on the input channel
  typedef enum logic [2:0] {
    OP_MODE  = 3'd0,
    OP_UP    = 3'd1,
    OP_DOWN  = 3'd2,
    OP_BLINK = 3'd3,
    OP_LOAD  = 3'd4
  } op_t;

  // edit modes: run, then the field under edit
  localparam logic [2:0] MODE_RUN     = 3'd0;
  localparam logic [2:0] MODE_SEC     = 3'd1;
  localparam logic [2:0] MODE_MIN     = 3'd2;
  localparam logic [2:0] MODE_HOUR    = 3'd3;
  localparam logic [2:0] MODE_YEAR    = 3'd4;
  localparam logic [2:0] MODE_MONTH   = 3'd5;
  localparam logic [2:0] MODE_DAY     = 3'd6;
  localparam logic [2:0] MODE_WEEKDAY = 3'd7;

  // display pages
  localparam logic [1:0] PAGE_NORMAL  = 2'd0;
  localparam logic [1:0] PAGE_TIME    = 2'd1;
  localparam logic [1:0] PAGE_DATE    = 2'd2;
  localparam logic [1:0] PAGE_WEEKDAY = 2'd3;

  // RTC register numbers
  localparam logic [2:0] REG_SEC   = 3'd0;
  localparam logic [2:0] REG_MIN   = 3'd1;
  localparam logic [2:0] REG_HOUR  = 3'd2;
  localparam logic [2:0] REG_WDAY  = 3'd3;
  localparam logic [2:0] REG_DAY   = 3'd4;
  localparam logic [2:0] REG_MONTH = 3'd5;
  localparam logic [2:0] REG_YEAR  = 3'd6;

  // clock and calendar state
  typedef struct packed {
    logic [2:0] mode;
    logic [1:0] page;
    logic [7:0] sec;
    logic [7:0] min;
    logic [7:0] hour;
    logic [7:0] day;
    logic [7:0] month;
    logic [7:0] year;
    logic [3:0] wday;
    logic [2:0] blink;
  } clk_state_t;

  // RTC write report
  typedef struct packed {
    logic       valid;
    logic [2:0] reg_id;
    logic [7:0] data;
  } rtc_wr_t;

  // loaded fields from the RTC
  typedef struct packed {
    logic [6:0] sec;
    logic [6:0] min;
    logic [5:0] hour;
    logic [5:0] day;
    logic [4:0] month;
    logic [7:0] year;
    logic [3:0] wday;
  } load_t;

  localparam clk_state_t STATE_RESET = '{
    mode:  MODE_RUN,
    page:  PAGE_NORMAL,
    sec:   8'h00,
    min:   8'h00,
    hour:  8'h00,
    day:   8'h01,
    month: 8'h01,
    year:  8'h00,
    wday:  4'd2,
    blink: 3'b111
  };

endpackage

// ----- hw/rtl/bcfs_step.sv -----
// ----------------------------------------------------------------------------
// bcfs_step
// Next-state logic for one event: mode stepping, BCD up/down adjust with
// per-field wrap, blink toggling and field load. Also forms the RTC write.
// ----------------------------------------------------------------------------
module bcfs_step (
  input  bcfs_pkg::clk_state_t cur_st,
  input  logic [2:0]           op,
  input  bcfs_pkg::load_t      ld,
  output bcfs_pkg::clk_state_t nxt_st,
  output bcfs_pkg::rtc_wr_t    wr
);
  import bcfs_pkg::*;

  // step a packed BCD byte by one, decimal value mod 256, then repack
  function automatic logic [7:0] bcd_step(input logic [7:0] v, input logic down);
    logic [7:0]  n;
    logic [15:0] prod;
    logic [4:0]  q;
    logic [7:0]  r;
    n    = 8'({4'b0, v[7:4]} * 8'd10) + {4'b0, v[3:0]};
    n    = down ? n - 8'd1 : n + 8'd1;
    // divide by ten via reciprocal, exact below 1029
    prod = {8'b0, n} * 16'd205;
    q    = prod[15:11];
    r    = n - 8'({3'b0, q} * 8'd10);
    return {q[3:0], r[3:0]};
  endfunction

  logic       down;
  logic [7:0] fld;
  logic [7:0] lo;
  logic [7:0] hi;
  logic [7:0] fld_new;
  logic [3:0] wday_new;
  logic [2:0] mode_inc;

  assign down = (op == OP_DOWN);

  // pick the field under edit with its wrap limits
  always_comb begin
    fld = cur_st.sec;
    lo  = 8'h00;
    hi  = 8'h59;
    case (cur_st.mode)
      MODE_SEC: begin
        fld = cur_st.sec;
      end
      MODE_MIN: begin
        fld = cur_st.min;
      end
      MODE_HOUR: begin
        fld = cur_st.hour;
        hi  = 8'h23;
      end
      MODE_YEAR: begin
        fld = cur_st.year;
        hi  = 8'h99;
      end
      MODE_MONTH: begin
        fld = cur_st.month;
        lo  = 8'h01;
        hi  = 8'h12;
      end
      MODE_DAY: begin
        fld = cur_st.day;
        lo  = 8'h01;
        hi  = 8'h31;
      end
      default: begin
        fld = cur_st.sec;
      end
    endcase
  end

  // wrapped adjust of the selected BCD field
  always_comb begin
    if (!down && fld == hi) begin
      fld_new = lo;
    end else if (down && fld == lo) begin
      fld_new = hi;
    end else begin
      fld_new = bcd_step(fld, down);
    end
  end

  // weekday runs 2..8
  always_comb begin
    if (down) begin
      wday_new = (cur_st.wday == 4'd2) ? 4'd8 : cur_st.wday - 4'd1;
    end else begin
      wday_new = (cur_st.wday == 4'd8) ? 4'd2 : cur_st.wday + 4'd1;
    end
  end

  assign mode_inc = cur_st.mode + 3'd1;

  // event dispatch
  always_comb begin
    nxt_st = cur_st;
    wr     = '0;
    case (op)
      OP_MODE: begin
        nxt_st.mode = mode_inc;
        case (mode_inc) inside
          [MODE_SEC:MODE_HOUR]:  nxt_st.page = PAGE_TIME;
          [MODE_YEAR:MODE_DAY]:  nxt_st.page = PAGE_DATE;
          MODE_WEEKDAY:          nxt_st.page = PAGE_WEEKDAY;
          default:               nxt_st.page = PAGE_NORMAL;
        endcase
      end
      OP_UP, OP_DOWN: begin
        nxt_st.blink = 3'b111;
        if (cur_st.mode != MODE_RUN) begin
          wr.valid = 1'b1;
          wr.data  = fld_new;
          case (cur_st.mode)
            MODE_SEC: begin
              nxt_st.sec = fld_new;
              wr.reg_id  = REG_SEC;
            end
            MODE_MIN: begin
              nxt_st.min = fld_new;
              wr.reg_id  = REG_MIN;
            end
            MODE_HOUR: begin
              nxt_st.hour = fld_new;
              wr.reg_id   = REG_HOUR;
            end
            MODE_YEAR: begin
              nxt_st.year = fld_new;
              wr.reg_id   = REG_YEAR;
            end
            MODE_MONTH: begin
              nxt_st.month = fld_new;
              wr.reg_id    = REG_MONTH;
            end
            MODE_DAY: begin
              nxt_st.day = fld_new;
              wr.reg_id  = REG_DAY;
            end
            default: begin
              nxt_st.wday = wday_new;
              wr.reg_id   = REG_WDAY;
              wr.data     = {4'b0, wday_new};
            end
          endcase
        end
      end
      OP_BLINK: begin
        case (cur_st.mode)
          MODE_SEC, MODE_YEAR:  nxt_st.blink = {2'b11, ~cur_st.blink[0]};
          MODE_MIN, MODE_MONTH: nxt_st.blink = {1'b1, ~cur_st.blink[1], 1'b1};
          MODE_HOUR, MODE_DAY:  nxt_st.blink = {~cur_st.blink[2], 2'b11};
          default:              nxt_st.blink = 3'b111;
        endcase
      end
      OP_LOAD: begin
        nxt_st.sec   = {1'b0, ld.sec};
        nxt_st.min   = {1'b0, ld.min};
        nxt_st.hour  = {2'b0, ld.hour};
        nxt_st.day   = {2'b0, ld.day};
        nxt_st.month = {3'b0, ld.month};
        nxt_st.year  = ld.year;
        nxt_st.wday  = ld.wday;
      end
      default: begin
        nxt_st = cur_st;
      end
    endcase
  end

endmodule

// ----- hw/rtl/bcfs_view.sv -----
// ----------------------------------------------------------------------------
// bcfs_view
// Display page selection: picks the three shown values and their enables
// from the clock state after an event.
// ----------------------------------------------------------------------------
module bcfs_view (
  input  bcfs_pkg::clk_state_t st,
  output logic [7:0]           show_first,
  output logic [7:0]           show_second,
  output logic [7:0]           show_third,
  output logic [2:0]           enable
);
  import bcfs_pkg::*;

  logic [1:0] shown;

  // page on screen: run mode follows the page, edit modes follow the field
  always_comb begin
    case (st.mode) inside
      MODE_RUN:             shown = (st.page == PAGE_NORMAL) ? PAGE_TIME : st.page;
      [MODE_SEC:MODE_HOUR]: shown = PAGE_TIME;
      [MODE_YEAR:MODE_DAY]: shown = PAGE_DATE;
      default:              shown = PAGE_WEEKDAY;
    endcase
  end

  // value and enable mux
  always_comb begin
    case (shown)
      PAGE_TIME: begin
        show_first  = st.hour;
        show_second = st.min;
        show_third  = st.sec;
        enable      = st.blink;
      end
      PAGE_DATE: begin
        show_first  = st.day;
        show_second = st.month;
        show_third  = st.year;
        enable      = st.blink;
      end
      default: begin
        show_first  = 8'h00;
        show_second = {4'b0, st.wday};
        show_third  = 8'h00;
        enable      = {1'b0, st.blink[1], 1'b0};
      end
    endcase
  end

endmodule

// ----- hw/rtl/bcd_clock_field_setter_unit.sv -----
// ----------------------------------------------------------------------------
// bcd_clock_field_setter_unit
// BCD clock and calendar with a button-driven set mode.
//
// Input channel (in_valid/in_ready) carries one event per transaction:
// mode button, up, down, blink tick, or a load of fields read back from the
// RTC. Every event produces exactly one transaction on the result channel
// (out_valid/out_ready): current mode and page, an optional RTC register
// write, and the three shown values with their display enables.
// The accepted event sits in the input register while the next-state
// logic works on it; the result register then loads the outcome and
// out_valid rises. Throughput is one event per clock while the receiver
// keeps up; the input register and the result register each advance
// whenever the stage after them is free.
// When the receiver stalls, the result register holds, then the input
// register fills and in_ready drops.
// Reset clears both valid flags and returns the clock to 00:00:00,
// day 01, month 01, year 00, weekday 2, run mode, all enables on.
// ----------------------------------------------------------------------------
module bcd_clock_field_setter_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_op,
  input  logic [6:0] in_load_seconds,
  input  logic [6:0] in_load_minutes,
  input  logic [5:0] in_load_hours,
  input  logic [5:0] in_load_day,
  input  logic [4:0] in_load_month,
  input  logic [7:0] in_load_year,
  input  logic [3:0] in_load_weekday,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_mode,
  output logic [1:0] out_page,
  output logic       out_write_valid,
  output logic [2:0] out_write_reg,
  output logic [7:0] out_write_data,
  output logic [7:0] out_show_first,
  output logic [7:0] out_show_second,
  output logic [7:0] out_show_third,
  output logic       out_enable_first,
  output logic       out_enable_second,
  output logic       out_enable_third
);
  import bcfs_pkg::*;

  logic       in_vld_r;
  logic [2:0] op_r;
  load_t      ld_r;
  clk_state_t st_r;
  clk_state_t st_nxt;
  rtc_wr_t    wr_nxt;
  logic       advance;
  logic [7:0] show1_nxt;
  logic [7:0] show2_nxt;
  logic [7:0] show3_nxt;
  logic [2:0] en_nxt;

  // result register
  logic       out_vld_r;
  logic [2:0] mode_r;
  logic [1:0] page_r;
  rtc_wr_t    wr_r;
  logic [7:0] show1_r;
  logic [7:0] show2_r;
  logic [7:0] show3_r;
  logic [2:0] en_r;

  // handshake: input stage moves when the result stage is free
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r       <= in_op;
      ld_r.sec   <= in_load_seconds;
      ld_r.min   <= in_load_minutes;
      ld_r.hour  <= in_load_hours;
      ld_r.day   <= in_load_day;
      ld_r.month <= in_load_month;
      ld_r.year  <= in_load_year;
      ld_r.wday  <= in_load_weekday;
    end
  end

  // event next-state logic
  bcfs_step u_step (
    .cur_st (st_r),
    .op     (op_r),
    .ld     (ld_r),
    .nxt_st (st_nxt),
    .wr     (wr_nxt)
  );

  // page formatting on the updated state
  bcfs_view u_view (
    .st          (st_nxt),
    .show_first  (show1_nxt),
    .show_second (show2_nxt),
    .show_third  (show3_nxt),
    .enable      (en_nxt)
  );

  // clock state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= STATE_RESET;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (advance) begin
      mode_r  <= st_nxt.mode;
      page_r  <= st_nxt.page;
      wr_r    <= wr_nxt;
      show1_r <= show1_nxt;
      show2_r <= show2_nxt;
      show3_r <= show3_nxt;
      en_r    <= en_nxt;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_mode          = mode_r;
  assign out_page          = page_r;
  assign out_write_valid   = wr_r.valid;
  assign out_write_reg     = wr_r.reg_id;
  assign out_write_data    = wr_r.data;
  assign out_show_first    = show1_r;
  assign out_show_second   = show2_r;
  assign out_show_third    = show3_r;
  assign out_enable_first  = en_r[2];
  assign out_enable_second = en_r[1];
  assign out_enable_third  = en_r[0];

endmodule
